@@ hdl/neg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// neg_pkg
// Shared types, constants and the decay factor table for the note echo
// generator.
// ----------------------------------------------------------------------------
package neg_pkg;

    localparam int MAX_REPEATS_DEF = 16;

    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int STEP_W   = 16;
    localparam int VEL_W    = 7;
    localparam int TRACK_W  = 8;
    localparam int COUNT_W  = 5;
    localparam int DELAY_W  = 8;
    localparam int DECAY_W  = 7;
    localparam int POW_W    = 17;
    localparam int PROD_W   = 2 * POW_W;
    localparam int FRAC_W   = 16;

    localparam int DECAY_MAX = 100;
    localparam int DECAY_DIV = 100;

    localparam logic [DECAY_W-1:0]  DECAY_RESET   = DECAY_W'(DECAY_MAX);
    localparam logic [STEP_W-1:0]   SEQ_LEN_RESET = '1;
    localparam logic [POW_W-1:0]    POW_ONE       = POW_W'(1 << FRAC_W);

    typedef enum logic [1:0] {
        REG_ECHO_COUNT,
        REG_ECHO_DELAY,
        REG_DECAY_PERCENT,
        REG_SEQUENCE_LENGTH
    } neg_reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POWER,
        ST_EVAL,
        ST_FLUSH
    } neg_state_t;

    typedef struct packed {
        logic [COUNT_W-1:0] echo_count;
        logic [DELAY_W-1:0] echo_delay;
        logic [DECAY_W-1:0] decay_percent;
        logic [STEP_W-1:0]  sequence_length;
    } neg_cfg_t;

    typedef logic [POW_W-1:0] neg_decay_lut_t [0:DECAY_MAX];

    // Q1.16 retention factor for each whole percent
    function automatic neg_decay_lut_t build_decay_lut();
        neg_decay_lut_t lut;
        for (int d = 0; d <= DECAY_MAX; d++) begin
            lut[d] = POW_W'((d * (1 << FRAC_W)) / DECAY_DIV);
        end
        return lut;
    endfunction

    localparam neg_decay_lut_t DECAY_LUT = build_decay_lut();

endpackage
`default_nettype wire

@@ hdl/note_echo_generator_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// note_echo_generator_unit
// Turns one sequencer note into up to MAX_REPEATS delayed, decaying echoes.
// ----------------------------------------------------------------------------
// A note is taken when in_valid is high and in_stall low; echoes leave one
// per transaction on the output channel, highest repeat first, the final one
// carrying last_echo. A note whose echoes all fall past the sequence length
// or decay to zero velocity produces no output at all. Each note goes
// through these steps: acceptance, computing the Q1.16 decay powers for
// N repeats (the echo count clamped to MAX_REPEATS) into a small RAM,
// evaluating the echoes from that RAM, and flushing the held final echo;
// when N is zero, only acceptance takes place. Both phases run through a
// single shared 17x17 multiplier.
// in_stall stays high until the note is fully handled. Program the
// registers only while the block is idle.
// ----------------------------------------------------------------------------
module note_echo_generator_unit #(
    parameter int MAX_REPEATS = neg_pkg::MAX_REPEATS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [neg_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [neg_pkg::PDATA_W-1:0]  pwdata,
    output logic      [neg_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [neg_pkg::STEP_W-1:0]   note_start,
    input  wire logic [neg_pkg::STEP_W-1:0]   note_end,
    input  wire logic [neg_pkg::VEL_W-1:0]    note_velocity,
    input  wire logic [neg_pkg::TRACK_W-1:0]  track_index,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [neg_pkg::STEP_W-1:0]   echo_start,
    output logic      [neg_pkg::STEP_W-1:0]   echo_end,
    output logic      [neg_pkg::VEL_W-1:0]    echo_velocity,
    output logic      [neg_pkg::TRACK_W-1:0]  echo_track,
    output logic                              last_echo
);

    import neg_pkg::*;

    // Power RAM address width
    localparam int ADDR_W = (MAX_REPEATS > 1) ? $clog2(MAX_REPEATS) : 1;

    neg_cfg_t            cfg;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [POW_W-1:0]    ram_wdata;
    logic [POW_W-1:0]    ram_rdata;
    logic [POW_W-1:0]    mul_a;
    logic [POW_W-1:0]    mul_b;
    logic [PROD_W-1:0]   mul_prod;

    // Configuration registers
    neg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Decay powers, one entry per repeat, indexed by repeat minus one
    neg_ram #(
        .WIDTH (POW_W),
        .DEPTH (MAX_REPEATS),
        .AW    (ADDR_W)
    ) u_pow_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Single multiplier shared by power build-up and velocity scaling
    neg_mul u_mul (
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    // Sequencer: power pass, echo walk, final flush
    neg_seq #(
        .MAX_REPEATS (MAX_REPEATS),
        .ADDR_W      (ADDR_W)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .note_start    (note_start),
        .note_end      (note_end),
        .note_velocity (note_velocity),
        .track_index   (track_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .echo_start    (echo_start),
        .echo_end      (echo_end),
        .echo_velocity (echo_velocity),
        .echo_track    (echo_track),
        .last_echo     (last_echo),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .mul_a         (mul_a),
        .mul_b         (mul_b),
        .mul_prod      (mul_prod)
    );

endmodule
`default_nettype wire

@@ hdl/neg_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// neg_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module neg_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ hdl/neg_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// neg_mul
// Shared unsigned multiplier used for both the decay powers and the
// velocity scaling.
// ----------------------------------------------------------------------------
module neg_mul (
    input  wire logic [neg_pkg::POW_W-1:0]  a,
    input  wire logic [neg_pkg::POW_W-1:0]  b,
    output logic      [neg_pkg::PROD_W-1:0] prod
);

    import neg_pkg::*;

    assign prod = PROD_W'(a) * PROD_W'(b);

endmodule
`default_nettype wire

@@ hdl/neg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// neg_regs
// APB-style configuration register file.
// ----------------------------------------------------------------------------
module neg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [neg_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [neg_pkg::PDATA_W-1:0]  pwdata,
    output logic      [neg_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    output neg_pkg::neg_cfg_t                 cfg
);

    import neg_pkg::*;

    neg_cfg_t     cfg_reg;
    neg_reg_idx_t reg_idx;
    logic         wr_en;

    assign reg_idx = neg_reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.echo_count      <= '0;
            cfg_reg.echo_delay      <= '0;
            cfg_reg.decay_percent   <= DECAY_RESET;
            cfg_reg.sequence_length <= SEQ_LEN_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ECHO_COUNT:      cfg_reg.echo_count      <= pwdata[COUNT_W-1:0];
                REG_ECHO_DELAY:      cfg_reg.echo_delay      <= pwdata[DELAY_W-1:0];
                REG_DECAY_PERCENT:   cfg_reg.decay_percent   <= pwdata[DECAY_W-1:0];
                REG_SEQUENCE_LENGTH: cfg_reg.sequence_length <= pwdata[STEP_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ECHO_COUNT:      prdata = PDATA_W'(cfg_reg.echo_count);
            REG_ECHO_DELAY:      prdata = PDATA_W'(cfg_reg.echo_delay);
            REG_DECAY_PERCENT:   prdata = PDATA_W'(cfg_reg.decay_percent);
            REG_SEQUENCE_LENGTH: prdata = PDATA_W'(cfg_reg.sequence_length);
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/neg_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// neg_seq
// Sequencer and datapath: builds the decay powers, then walks the repeats
// from the highest down, holding one echo back so the final one is flagged.
// ----------------------------------------------------------------------------
module neg_seq #(
    parameter int MAX_REPEATS = neg_pkg::MAX_REPEATS_DEF,
    parameter int ADDR_W      = (MAX_REPEATS > 1) ? $clog2(MAX_REPEATS) : 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire neg_pkg::neg_cfg_t            cfg,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [neg_pkg::STEP_W-1:0]   note_start,
    input  wire logic [neg_pkg::STEP_W-1:0]   note_end,
    input  wire logic [neg_pkg::VEL_W-1:0]    note_velocity,
    input  wire logic [neg_pkg::TRACK_W-1:0]  track_index,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [neg_pkg::STEP_W-1:0]   echo_start,
    output logic      [neg_pkg::STEP_W-1:0]   echo_end,
    output logic      [neg_pkg::VEL_W-1:0]    echo_velocity,
    output logic      [neg_pkg::TRACK_W-1:0]  echo_track,
    output logic                              last_echo,
    output logic                              ram_we,
    output logic      [ADDR_W-1:0]            ram_waddr,
    output logic      [neg_pkg::POW_W-1:0]    ram_wdata,
    output logic      [ADDR_W-1:0]            ram_raddr,
    input  wire logic [neg_pkg::POW_W-1:0]    ram_rdata,
    output logic      [neg_pkg::POW_W-1:0]    mul_a,
    output logic      [neg_pkg::POW_W-1:0]    mul_b,
    input  wire logic [neg_pkg::PROD_W-1:0]   mul_prod
);

    import neg_pkg::*;

    localparam int IDX_W = $clog2(MAX_REPEATS + 1);
    localparam int OFF_W = IDX_W + DELAY_W;
    localparam logic [7:0] MAX_CNT = 8'(MAX_REPEATS);

    neg_state_t state_reg, state_next;

    logic [STEP_W-1:0]  start_reg, end_reg;
    logic [VEL_W-1:0]   vel_reg;
    logic [TRACK_W-1:0] track_reg;
    logic [POW_W-1:0]   f_reg, p_reg;
    logic [IDX_W-1:0]   cnt_reg, idx_reg, idx_next;
    logic [OFF_W-1:0]   off_reg;
    logic               first_reg;

    logic               pend_valid_reg;
    logic [STEP_W-1:0]  pend_start_reg, pend_end_reg;
    logic [VEL_W-1:0]   pend_vel_reg;

    logic               out_valid_reg;
    logic [STEP_W-1:0]  out_start_reg, out_end_reg;
    logic [VEL_W-1:0]   out_vel_reg;
    logic [TRACK_W-1:0] out_track_reg;
    logic               out_last_reg;

    logic [7:0]         cnt_wide;
    logic [IDX_W-1:0]   cnt_eff;
    logic [DECAY_W-1:0] decay_idx;
    logic               accept;
    logic [POW_W-1:0]   p_use;
    logic [POW_W-1:0]   pow_new;
    logic [VEL_W-1:0]   vel_new;
    logic [STEP_W:0]    end_sum;
    logic               cand_ok;
    logic               slot_free;
    logic               advance;
    logic               pend_to_out;
    logic               flush_out;
    logic               power_done;

    assign cnt_wide  = 8'(cfg.echo_count);
    assign cnt_eff   = (cnt_wide > MAX_CNT) ? IDX_W'(MAX_REPEATS) : IDX_W'(cfg.echo_count);
    assign decay_idx = (cfg.decay_percent > DECAY_W'(DECAY_MAX)) ? DECAY_W'(DECAY_MAX)
                                                                 : cfg.decay_percent;

    assign accept    = in_valid & (state_reg == ST_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;

    // Newest power is still in flight to the RAM on the first evaluation
    assign p_use   = first_reg ? p_reg : ram_rdata;
    assign pow_new = mul_prod[FRAC_W +: POW_W];
    assign vel_new = mul_prod[FRAC_W +: VEL_W];

    assign end_sum = {1'b0, end_reg} + (STEP_W + 1)'(off_reg);
    assign cand_ok = (end_sum <= {1'b0, cfg.sequence_length}) && (vel_new != '0);

    assign power_done = (idx_reg == cnt_reg - IDX_W'(1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cnt_eff != '0))
                begin
                    state_next = ST_POWER;
                end
            end
            ST_POWER:
            begin
                if (power_done)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (advance && (idx_reg == IDX_W'(1)))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Control and shared-unit steering
    always_comb
    begin
        in_stall    = 1'b1;
        ram_we      = 1'b0;
        advance     = 1'b0;
        pend_to_out = 1'b0;
        flush_out   = 1'b0;
        mul_a       = POW_W'(vel_reg);
        mul_b       = p_use;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_POWER:
            begin
                ram_we = 1'b1;
                mul_a  = p_reg;
                mul_b  = f_reg;
            end
            ST_EVAL:
            begin
                advance     = !cand_ok || !pend_valid_reg || slot_free;
                pend_to_out = advance && cand_ok && pend_valid_reg;
            end
            ST_FLUSH:
            begin
                flush_out = pend_valid_reg && slot_free;
            end
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (accept)
        begin
            idx_next = '0;
        end
        else if (state_reg == ST_POWER)
        begin
            idx_next = power_done ? cnt_reg : idx_reg + IDX_W'(1);
        end
        else if (advance)
        begin
            idx_next = idx_reg - IDX_W'(1);
        end
    end

    assign ram_waddr = ADDR_W'(idx_reg);
    assign ram_wdata = pow_new;
    assign ram_raddr = ADDR_W'(idx_next - IDX_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (advance && cand_ok)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (flush_out)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (pend_to_out || flush_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (accept)
        begin
            start_reg <= note_start;
            end_reg   <= note_end;
            vel_reg   <= note_velocity;
            track_reg <= track_index;
            cnt_reg   <= cnt_eff;
            f_reg     <= DECAY_LUT[decay_idx];
            p_reg     <= POW_ONE;
            off_reg   <= '0;
            first_reg <= 1'b1;
        end
        else if (state_reg == ST_POWER)
        begin
            p_reg   <= pow_new;
            off_reg <= off_reg + OFF_W'(cfg.echo_delay);
        end
        else if (advance)
        begin
            off_reg   <= off_reg - OFF_W'(cfg.echo_delay);
            first_reg <= 1'b0;
        end

        if (advance && cand_ok)
        begin
            pend_start_reg <= start_reg + STEP_W'(off_reg);
            pend_end_reg   <= end_reg + STEP_W'(off_reg);
            pend_vel_reg   <= vel_new;
        end

        if (pend_to_out || flush_out)
        begin
            out_start_reg <= pend_start_reg;
            out_end_reg   <= pend_end_reg;
            out_vel_reg   <= pend_vel_reg;
            out_track_reg <= track_reg;
            out_last_reg  <= flush_out;
        end
    end

    assign out_valid     = out_valid_reg;
    assign echo_start    = out_start_reg;
    assign echo_end      = out_end_reg;
    assign echo_velocity = out_vel_reg;
    assign echo_track    = out_track_reg;
    assign last_echo     = out_last_reg;

endmodule
`default_nettype wire

@@ bench/note_echo_generator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// note_echo_generator_unit_tb
// Self-checking bench for the note echo generator: notes go in over a
// valid/stall channel, every echo coming back is compared with a predicted
// copy, and the registers are reprogrammed between idle phases.
// ----------------------------------------------------------------------------
module note_echo_generator_unit_tb;

    import neg_pkg::*;

    localparam int          REPEATS       = MAX_REPEATS_DEF;
    // settle time: long enough for one note's pass through the block, with slack
    localparam int          SETTLE_CYCLES = 2 * REPEATS + 16;
    localparam int unsigned CYCLE_LIMIT   = 600000;

    typedef struct {
        logic [STEP_W-1:0]  start_step;
        logic [STEP_W-1:0]  end_step;
        logic [VEL_W-1:0]   velocity;
        logic [TRACK_W-1:0] track;
    } note_t;

    typedef struct {
        logic [STEP_W-1:0]  start_step;
        logic [STEP_W-1:0]  end_step;
        logic [VEL_W-1:0]   velocity;
        logic [TRACK_W-1:0] track;
        logic               last_flag;
    } echo_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [PADDR_W-1:0]  paddr         = '0;
    logic [PDATA_W-1:0]  pwdata        = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic [STEP_W-1:0]   note_start    = '0;
    logic [STEP_W-1:0]   note_end      = '0;
    logic [VEL_W-1:0]    note_velocity = '0;
    logic [TRACK_W-1:0]  track_index   = '0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic [STEP_W-1:0]   echo_start;
    logic [STEP_W-1:0]   echo_end;
    logic [VEL_W-1:0]    echo_velocity;
    logic [TRACK_W-1:0]  echo_track;
    logic                last_echo;

    // register copy as the block should hold it; starts at the reset values
    neg_cfg_t    cfg_shadow = '{echo_count: '0, echo_delay: '0,
                                decay_percent: DECAY_RESET,
                                sequence_length: SEQ_LEN_RESET};

    note_t       note_queue [$];     // notes waiting to be sent
    echo_t       pending_echoes [$]; // echoes predicted but not yet seen
    note_t       on_wire;            // note currently offered to the block
    int unsigned send_gap   = 0;
    int unsigned stall_left = 0;
    int unsigned mismatches = 0;
    int unsigned cycles     = 0;
    bit          idling     = 1'b1;  // allow random gaps and stalls

    note_echo_generator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .note_start    (note_start),
        .note_end      (note_end),
        .note_velocity (note_velocity),
        .track_index   (track_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .echo_start    (echo_start),
        .echo_end      (echo_end),
        .echo_velocity (echo_velocity),
        .echo_track    (echo_track),
        .last_echo     (last_echo)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop in case the block hangs or drops echoes.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction: work out every echo a note produces under the current
    // register copy and append them, in emission order, to pending_echoes.
    // Repeats run from the clamped count down to one; the decay power is
    // truncated at each step, so build the table first.
    // ------------------------------------------------------------------------
    function automatic void predict_echoes(note_t note);
        int unsigned     reps;
        int unsigned     pct;
        int unsigned     factor;
        longint unsigned power;
        int unsigned     powers [0:REPEATS];
        int unsigned     offset;
        int unsigned     vel;
        echo_t           fresh [$];
        echo_t           e;
        // clamp count and retention to their limits
        reps   = (cfg_shadow.echo_count > REPEATS) ? REPEATS : cfg_shadow.echo_count;
        pct    = (cfg_shadow.decay_percent > DECAY_MAX) ? DECAY_MAX
                                                        : cfg_shadow.decay_percent;
        factor = (pct << FRAC_W) / DECAY_DIV;
        power  = 64'd1 << FRAC_W;
        for (int k = 1; k <= reps; k++)
        begin
            power     = (power * factor) >> FRAC_W;
            powers[k] = int'(power);
        end
        for (int i = reps; i > 0; i--)
        begin
            offset = (i * cfg_shadow.echo_delay) & 32'hFFFF;
            // drop echoes that run past the sequence or fade to silence
            if (note.end_step + offset <= cfg_shadow.sequence_length)
            begin
                vel = (note.velocity * powers[i]) >> FRAC_W;
                if (vel != 0)
                begin
                    e.start_step = STEP_W'(note.start_step + offset);
                    e.end_step   = STEP_W'(note.end_step + offset);
                    e.velocity   = VEL_W'(vel);
                    e.track      = note.track;
                    e.last_flag  = 1'b0;
                    fresh.insert(fresh.size(), e);
                end
            end
        end
        if (fresh.size() != 0)
            fresh[fresh.size() - 1].last_flag = 1'b1;
        foreach (fresh[j])
            pending_echoes.insert(pending_echoes.size(), fresh[j]);
    endfunction

    function automatic void check_field(string label, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offer notes from note_queue. Hold the payload while stalled,
    // predict at the accepting edge, then optionally idle before the next
    // transaction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_echoes(on_wire);
                send_gap = (idling && $urandom_range(0, 2) == 0) ? $urandom_range(1, 18) : 0;
            end
            if (in_valid && in_stall)
            begin
                // hold: a stalled payload must not change
            end
            else if (send_gap != 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (note_queue.size() != 0)
            begin
                on_wire        = note_queue.pop_front();
                in_valid      <= 1'b1;
                note_start    <= on_wire.start_step;
                note_end      <= on_wire.end_step;
                note_velocity <= on_wire.velocity;
                track_index   <= on_wire.track;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each accepted echo with the oldest prediction, then
    // decide the stall for the next cycle in random bursts.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_echoes.size() == 0)
                begin
                    $display("%0t: unexpected echo, expected none, actual start %0d end %0d vel %0d",
                             $time, echo_start, echo_end, echo_velocity);
                    mismatches++;
                end
                else
                begin
                    echo_t want;
                    want = pending_echoes.pop_front();
                    check_field("echo_start", 32'(want.start_step), 32'(echo_start));
                    check_field("echo_end", 32'(want.end_step), 32'(echo_end));
                    check_field("echo_velocity", 32'(want.velocity), 32'(echo_velocity));
                    check_field("echo_track", 32'(want.track), 32'(echo_track));
                    check_field("last_echo", 32'(want.last_flag), 32'(last_echo));
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (idling && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 17);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Register access: setup then access cycle, with junk above the field so
    // the block has to ignore the unused bits.
    // ------------------------------------------------------------------------
    task automatic write_reg(input neg_reg_idx_t idx, input int unsigned value);
        int unsigned        w;
        logic [PDATA_W-1:0] word;
        case (idx)
            REG_ECHO_COUNT:    w = COUNT_W;
            REG_ECHO_DELAY:    w = DELAY_W;
            REG_DECAY_PERCENT: w = DECAY_W;
            default:           w = STEP_W;
        endcase
        word = (($urandom >> w) << w) | (value & ((32'd1 << w) - 1));
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ECHO_COUNT:    cfg_shadow.echo_count      = word[COUNT_W-1:0];
            REG_ECHO_DELAY:    cfg_shadow.echo_delay      = word[DELAY_W-1:0];
            REG_DECAY_PERCENT: cfg_shadow.decay_percent   = word[DECAY_W-1:0];
            default:           cfg_shadow.sequence_length = word[STEP_W-1:0];
        endcase
    endtask

    task automatic set_config(input int unsigned count, input int unsigned delay,
                              input int unsigned decay, input int unsigned seq_len);
        write_reg(REG_ECHO_COUNT, count);
        write_reg(REG_ECHO_DELAY, delay);
        write_reg(REG_DECAY_PERCENT, decay);
        write_reg(REG_SEQUENCE_LENGTH, seq_len);
    endtask

    // Queue a note; call only just after a falling edge.
    task automatic add_note(input int unsigned s, input int unsigned e,
                            input int unsigned v, input int unsigned t);
        note_t n;
        n.start_step = STEP_W'(s);
        n.end_step   = STEP_W'(e);
        n.velocity   = VEL_W'(v);
        n.track      = TRACK_W'(t);
        note_queue.insert(note_queue.size(), n);
    endtask

    // Wait until every note is sent and every echo seen, then let a note
    // with no echoes finish its internal pass before anything else happens.
    task automatic drain();
        do
            @(negedge clk);
        while (note_queue.size() != 0 || in_valid || pending_echoes.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mostly notes whose echoes fit inside the sequence, with some noise.
    function automatic note_t random_note();
        note_t n;
        n.track = TRACK_W'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
        begin
            n.start_step = STEP_W'($urandom);
            n.end_step   = STEP_W'($urandom);
        end
        else
        begin
            n.end_step   = STEP_W'($urandom_range(0, cfg_shadow.sequence_length >> 1));
            n.start_step = n.end_step - STEP_W'($urandom_range(0, 300));
        end
        case ($urandom_range(0, 7))
            0:       n.velocity = '0;
            1:       n.velocity = 7'd127;
            default: n.velocity = VEL_W'($urandom_range(1, 127));
        endcase
        return n;
    endfunction

    task automatic random_batch(input int unsigned n);
        @(negedge clk);
        repeat (n) note_queue.insert(note_queue.size(), random_note());
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned count;
        int unsigned delay;
        int unsigned decay;
        int unsigned seq_len;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: no repeats, so nothing comes out
        @(negedge clk);
        add_note(0, 0, 127, 0);
        add_note(65535, 65535, 127, 255);
        drain();

        // full count, wide spacing, no decay
        set_config(16, 192, 100, 65535);
        @(negedge clk);
        add_note(0, 0, 127, 0);
        add_note(65535, 10, 127, 255);   // start after end: start wraps
        add_note(100, 65535, 127, 1);    // every echo past the sequence end
        add_note(5, 6, 0, 3);            // silent note: every echo dropped
        add_note(7, 8, 1, 170);
        drain();

        // count and retention above their limits, zero spacing and length
        set_config(31, 0, 127, 0);
        @(negedge clk);
        add_note(0, 0, 127, 85);
        add_note(0, 1, 100, 2);
        drain();

        // full decay: nothing survives
        set_config(1, 255, 0, 65535);
        @(negedge clk);
        add_note(10, 20, 127, 9);
        drain();

        // half retention: late repeats fade out, some run past the length
        set_config(16, 7, 50, 1000);
        @(negedge clk);
        add_note(0, 5, 127, 4);
        add_note(3, 2, 64, 8);
        add_note(900, 990, 127, 6);
        add_note(500, 1000, 127, 200);
        drain();

        // one percent: only the first repeat keeps any velocity
        set_config(5, 255, 1, 65535);
        @(negedge clk);
        add_note(0, 0, 127, 0);
        add_note(65500, 65535, 127, 128);
        drain();

        // random settings; one phase pauses the sender mid-way until idle
        for (int phase = 0; phase < 8; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       count = $urandom_range(17, 31);
                1:       count = $urandom_range(0, 3);
                default: count = $urandom_range(4, 16);
            endcase
            delay   = $urandom_range(0, 255);
            decay   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                  : $urandom_range(60, 100);
            seq_len = ($urandom_range(0, 1) == 0) ? 65535 : $urandom_range(0, 65535);
            set_config(count, delay, decay, seq_len);
            idling = (phase == 0) || ($urandom_range(0, 3) != 0);
            if (phase == 3)
            begin
                random_batch(15);
                random_batch(15);
            end
            else
                random_batch(30);
        end

        // closing stretch at full rate: no gaps and no stalls
        idling = 1'b0;
        set_config(16, $urandom_range(1, 40), $urandom_range(85, 100), 65535);
        random_batch(30);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
